// File: hdl/assert_macros.svh
// Assertion helpers used by the RTL (included by priority_queue_with_expiry)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// File: hdl/pqe_pkg.sv
package pqe_pkg;

    // one queue entry as held in the slot memory
    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  prio;
        logic [31:0] start;
        logic [31:0] tmo;
    } t_entry;

    typedef enum logic [2:0] {
        REQ_PUT    = 3'd0,
        REQ_GET    = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_HAS    = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_CLEAR_THR   = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_PRI = 2'd2;

    localparam logic [3:0] PRIO_TOP = 4'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_EV,
        S_CHECK,
        S_INS_RD,
        S_INS_EV,
        S_INS_NEW,
        S_FRONT_RD,
        S_FRONT_EV,
        S_DONE
    } t_state;

endpackage

// File: hdl/pqe_mem.sv
module pqe_mem
    import pqe_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: hdl/priority_queue_with_expiry.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_req_type .. i_now
// out     | output    | o_out_valid / i_out_stall | o_status .. o_entry_count
// cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
// One request at a time. Each pass over the queue visits one entry at a time
// (memory read, then evaluate and write back), set by the single slot memory.
// A put then walks back from the tail to insert the new entry in order.
// Reset (synchronous, active low) empties the queue and loads register defaults.
// A stalled output holds its result; the next request is taken once it is loaded.
`include "assert_macros.svh"
module priority_queue_with_expiry
    import pqe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_entry_id,
    input  logic [3:0]  i_priority_req,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_timeout_ms,
    input  logic [31:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_entry_id,
    output logic [3:0]  o_out_priority,
    output logic        o_found,
    output logic [3:0]  o_front_priority,
    output logic [4:0]  o_entry_count
);

    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    t_state r_state, n_state;

    logic [CW-1:0] r_cnt, r_k, r_w;
    logic [4:0]    r_max;
    logic [3:0]    r_thr, r_def;
    logic [2:0]    r_req;
    logic [15:0]   r_id;
    logic [3:0]    r_prio;
    logic [31:0]   r_start, r_tmo, r_now;
    logic          r_hit, r_found;
    logic [1:0]    r_status;
    logic [15:0]   r_oid;
    logic [3:0]    r_oprio, r_front;
    logic          r_out_valid;
    logic [1:0]    r_o_status;
    logic [15:0]   r_o_id;
    logic [3:0]    r_o_prio, r_o_front;
    logic          r_o_found;
    logic [4:0]    r_o_count;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    t_entry        rd_data, wr_data, new_entry;

    logic          drop, match, goes_after, full, last, out_load;
    logic [31:0]   age;
    logic [CW-1:0] w_next;

    pqe_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign new_entry = '{id: r_id, prio: r_prio, start: r_start, tmo: r_tmo};

    // per-entry decisions on the word just read
    always_comb begin
        age        = r_now - rd_data.start;
        match      = (rd_data.id == r_id);
        goes_after = (rd_data.prio > r_prio) ||
                     ((rd_data.prio == r_prio) && (rd_data.start > r_start));
        case (r_req)
            REQ_PUT:    drop = ((r_prio == PRIO_TOP) && (rd_data.prio >= r_thr)) ||
                               (age > rd_data.tmo);
            REQ_GET:    drop = (r_k == '0);
            REQ_REMOVE: drop = match && !r_hit;
            REQ_CLEAR:  drop = (rd_data.prio >= r_prio);
            default:    drop = 1'b0;
        endcase
        w_next = drop ? r_w : r_w + CW'(1);
        last   = (r_k == r_cnt - CW'(1));
        full   = (CMPW'(r_cnt) >= CMPW'(r_max)) || (r_cnt >= CW'(QUEUE_DEPTH));
    end

    assign out_load = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_START;
            S_START: begin
                if (r_req <= REQ_CLEAR && r_cnt != '0) n_state = S_RD;
                else if (r_req == REQ_PUT)             n_state = S_CHECK;
                else                                   n_state = S_FRONT_RD;
            end
            S_RD:       n_state = S_EV;
            S_EV: begin
                if (!last)                 n_state = S_RD;
                else if (r_req == REQ_PUT) n_state = S_CHECK;
                else                       n_state = S_FRONT_RD;
            end
            S_CHECK: begin
                if (full)            n_state = S_FRONT_RD;
                else if (r_cnt == '0) n_state = S_INS_NEW;
                else                  n_state = S_INS_RD;
            end
            S_INS_RD:   n_state = S_INS_EV;
            S_INS_EV: begin
                if (goes_after && r_k != CW'(1)) n_state = S_INS_RD;
                else                             n_state = S_INS_NEW;
            end
            S_INS_NEW:  n_state = S_FRONT_RD;
            S_FRONT_RD: n_state = S_FRONT_EV;
            S_FRONT_EV: n_state = S_DONE;
            S_DONE:     if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_k[AW-1:0];
        wr_data = rd_data;
        unique case (r_state)
            S_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_k[AW-1:0];
            end
            S_EV: begin
                wr_en   = !drop;
                wr_addr = r_w[AW-1:0];
            end
            S_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_k - CW'(1));
            end
            S_INS_EV:   wr_en = goes_after;
            S_INS_NEW: begin
                wr_en   = 1'b1;
                wr_data = new_entry;
            end
            S_FRONT_RD: rd_en = 1'b1;
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_max       <= 5'd16;
            r_thr       <= 4'd2;
            r_def       <= 4'd3;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_ENTRIES: r_max <= i_cfg_data;
                    CFG_CLEAR_THR:   r_thr <= i_cfg_data[3:0];
                    CFG_DEFAULT_PRI: r_def <= i_cfg_data[3:0];
                    default:         r_max <= r_max;
                endcase
            end
            if (r_state == S_EV && last) r_cnt <= w_next;
            if (r_state == S_INS_NEW)    r_cnt <= r_cnt + CW'(1);
            if (r_state == S_DONE && out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall)             r_out_valid <= 1'b0;
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req   <= i_req_type;
                r_id    <= i_entry_id;
                r_prio  <= i_priority_req;
                r_start <= i_start_time;
                r_tmo   <= i_timeout_ms;
                r_now   <= i_now;
            end
            S_START: begin
                r_k      <= '0;
                r_w      <= '0;
                r_hit    <= 1'b0;
                r_found  <= 1'b0;
                r_oid    <= '0;
                r_oprio  <= '0;
                r_status <= (r_req == REQ_GET && r_cnt == '0) ? ST_EMPTY : ST_OK;
            end
            S_EV: begin
                r_k <= r_k + CW'(1);
                r_w <= w_next;
                if (match) r_hit <= 1'b1;
                if (match && r_req == REQ_HAS) r_found <= 1'b1;
                if (r_req == REQ_GET && r_k == '0) begin
                    r_oid   <= rd_data.id;
                    r_oprio <= rd_data.prio;
                end
            end
            S_CHECK: begin
                r_k <= r_cnt;
                if (full) r_status <= ST_OVER;
            end
            S_INS_EV:   if (goes_after) r_k <= r_k - CW'(1);
            S_FRONT_EV: r_front <= (r_cnt != '0) ? rd_data.prio : r_def;
            default:    r_k <= r_k;
        endcase
        if (r_state == S_DONE && out_load) begin
            r_o_status <= r_status;
            r_o_id     <= r_oid;
            r_o_prio   <= r_oprio;
            r_o_found  <= r_found;
            r_o_front  <= r_front;
            r_o_count  <= 5'(r_cnt);
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_out_entry_id   = r_o_id;
    assign o_out_priority   = r_o_prio;
    assign o_found          = r_o_found;
    assign o_front_priority = r_o_front;
    assign o_entry_count    = r_o_count;

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(QUEUE_DEPTH), "count over depth")
    `ASSERT_IMPLY(a_compact_order, i_clk, i_rst_n, r_state == S_EV, r_w <= r_k, "write ahead of read")
    `ASSERT_IMPLY(a_no_ins_full, i_clk, i_rst_n, r_state == S_INS_NEW, r_cnt < CW'(QUEUE_DEPTH), "insert into full queue")
    `ASSERT_IMPLY(a_overload_keeps, i_clk, i_rst_n, r_state == S_INS_NEW, r_status == ST_OK, "insert after overload")

endmodule

// File: dv/testbench.sv
module testbench;
    import pqe_pkg::*;

    localparam int DEPTH      = 16;
    localparam int WATCHDOG   = 3000;
    localparam int SETTLE     = 90;   // longer than a full-queue put
    localparam int HOLD_LEN   = 300;
    localparam int PEND_DEPTH = 8;
    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic [3:0]  prio;
        logic        found;
        logic [3:0]  front;
        logic [4:0]  count;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [4:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [15:0] i_entry_id;
    logic [3:0]  i_priority_req;
    logic [31:0] i_start_time;
    logic [31:0] i_timeout_ms;
    logic [31:0] i_now;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [15:0] o_out_entry_id;
    logic [3:0]  o_out_priority;
    logic        o_found;
    logic [3:0]  o_front_priority;
    logic [4:0]  o_entry_count;

    priority_queue_with_expiry #(.QUEUE_DEPTH(DEPTH)) dut (.*);

    // queue model and its settings
    t_entry      model_slot [DEPTH];
    int          model_len;
    logic [4:0]  lim_entries;
    logic [3:0]  lim_clear_thr;
    logic [3:0]  lim_default_pri;

    // expected results, written by the sender and read by the checker
    t_result     pending_buf [PEND_DEPTH];
    int          pend_wr;
    int          pend_rd;
    int          errors;
    int          sent_items;
    int          got_results;
    int          idle_cycles;
    int          overloads;
    int          expirations;
    bit          hold_req;
    bit          quiet;
    logic [31:0] clock_ms;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ---------------- queue predictor ----------------
    function automatic void model_drop(int pos);
        for (int k = pos; k + 1 < model_len; k++) model_slot[k] = model_slot[k + 1];
        if (model_len > 0) model_len--;
    endfunction

    function automatic void model_drop_level(logic [3:0] lvl);
        int k;
        k = 0;
        while (k < model_len) begin
            if (model_slot[k].prio >= lvl) model_drop(k);
            else k++;
        end
    endfunction

    function automatic void model_expire(logic [31:0] tnow);
        int k;
        logic [31:0] age;
        k = 0;
        while (k < model_len) begin
            age = tnow - model_slot[k].start;
            if (age > model_slot[k].tmo) begin
                model_drop(k);
                expirations++;
            end else begin
                k++;
            end
        end
    endfunction

    function automatic int model_find(logic [15:0] id);
        for (int k = 0; k < model_len; k++)
            if (model_slot[k].id == id) return k;
        return -1;
    endfunction

    function automatic t_result serve_request(logic [2:0] req, t_entry e, logic [31:0] tnow);
        t_result r;
        int      ins;
        int      pos;
        r = '0;
        case (req)
            REQ_PUT: begin
                if (e.prio == PRIO_TOP) model_drop_level(lim_clear_thr);
                model_expire(tnow);
                if (model_len >= lim_entries || model_len >= DEPTH) begin
                    r.status = ST_OVER;
                    overloads++;
                end else begin
                    ins = 0;
                    while (ins < model_len && (model_slot[ins].prio < e.prio ||
                           (model_slot[ins].prio == e.prio &&
                            model_slot[ins].start <= e.start)))
                        ins++;
                    for (int k = model_len; k > ins; k--) model_slot[k] = model_slot[k - 1];
                    model_slot[ins] = e;
                    model_len++;
                end
            end
            REQ_GET: begin
                if (model_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.id   = model_slot[0].id;
                    r.prio = model_slot[0].prio;
                    model_drop(0);
                end
            end
            REQ_REMOVE: begin
                pos = model_find(e.id);
                if (pos >= 0) model_drop(pos);
            end
            REQ_HAS:   r.found = (model_find(e.id) >= 0);
            REQ_CLEAR: model_drop_level(e.prio);
            default: ;
        endcase
        r.front = (model_len > 0) ? model_slot[0].prio : lim_default_pri;
        r.count = model_len[4:0];
        return r;
    endfunction

    // ---------------- request sender ----------------
    task automatic send_req(logic [2:0] req, logic [15:0] id, logic [3:0] prio,
                            logic [31:0] start, logic [31:0] tmo, logic [31:0] tnow);
        t_entry e;
        int     gap;
        e.id    = id;
        e.prio  = prio;
        e.start = start;
        e.tmo   = tmo;
        i_req_type     <= req;
        i_entry_id     <= id;
        i_priority_req <= prio;
        i_start_time   <= start;
        i_timeout_ms   <= tmo;
        i_now          <= tnow;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // transfer taken at this edge
        pending_buf[pend_wr % PEND_DEPTH] = serve_request(req, e, tnow);
        pend_wr++;
        sent_items++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic put(logic [15:0] id, logic [3:0] prio, logic [31:0] start,
                       logic [31:0] tmo, logic [31:0] tnow);
        send_req(REQ_PUT, id, prio, start, tmo, tnow);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pend_wr != pend_rd) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [4:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_ENTRIES: lim_entries     = val;
            CFG_CLEAR_THR:   lim_clear_thr   = val[3:0];
            CFG_DEFAULT_PRI: lim_default_pri = val[3:0];
            default: ;
        endcase
    endtask

    // ---------------- result checker ----------------
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_results++;
            if (pend_wr == pend_rd) begin
                $display("%0t: result with nothing expected, expected none, actual status %0h",
                         $time, o_status);
                errors++;
            end else begin
                want = pending_buf[pend_rd % PEND_DEPTH];
                pend_rd++;
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("out_entry_id", 32'(want.id), 32'(o_out_entry_id));
                check_field("out_priority", 32'(want.prio), 32'(o_out_priority));
                check_field("found", 32'(want.found), 32'(o_found));
                check_field("front_priority", 32'(want.front), 32'(o_front_priority));
                check_field("entry_count", 32'(want.count), 32'(o_entry_count));
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                n = pick_gap();
                i_out_stall <= (n > 0);
                if (n > 1) repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pend_wr - pend_rd);
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_empty_defaults();
        send_req(REQ_GET, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_HAS, 16'hFFFF, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_REMOVE, 16'h1234, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_BAD_LO, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_BAD_HI, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_ordering_and_ops();
        // field extremes, ties on priority and start, wrapped ages
        put(16'h0000, 4'h0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0010);
        put(16'hFFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0010);
        put(16'h0101, 4'h7, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0010);
        put(16'h0102, 4'h7, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0010);
        put(16'h0103, 4'h7, 32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0010);
        send_req(REQ_HAS, 16'h0102, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_REMOVE, 16'h0101, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_HAS, 16'h0101, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_CLEAR, 16'h0, 4'h8, 32'h0, 32'h0, 32'h0);
        // age equal to the timeout survives, one more expires
        put(16'h0200, 4'h5, 32'hFFFF_FFF0, 32'd32, 32'h0000_0010);
        put(16'h0201, 4'h5, 32'hFFFF_FFF0, 32'd31, 32'h0000_0010);
        put(16'h0202, 4'h4, 32'h0000_0000, 32'd0, 32'h0000_0000);
        put(16'h0203, 4'h6, 32'h0000_0000, 32'd5, 32'h0000_0010);
        // top-priority put clears from the threshold up
        put(16'h0300, PRIO_TOP, 32'h0000_0010, 32'd100, 32'h0000_0010);
        repeat (3) send_req(REQ_GET, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_CLEAR, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_GET, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_limits();
        // smallest size: second put overloads, expiry still applied
        cfg_write(CFG_MAX_ENTRIES, 5'd1);
        cfg_write(CFG_CLEAR_THR, 5'd0);
        cfg_write(CFG_DEFAULT_PRI, 5'd15);
        send_req(REQ_GET, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
        put(16'h0400, 4'h9, 32'd100, 32'd10, 32'd100);
        put(16'h0401, 4'h2, 32'd100, 32'd10, 32'd105);
        put(16'h0402, 4'h2, 32'd100, 32'd10, 32'd200);
        put(16'h0403, PRIO_TOP, 32'd200, 32'd50, 32'd200);
        cfg_write(CFG_MAX_ENTRIES, 5'd16);
        cfg_write(CFG_CLEAR_THR, 5'd15);
        cfg_write(CFG_DEFAULT_PRI, 5'd0);
        // fill to the depth and overflow
        for (int k = 0; k < DEPTH + 2; k++)
            put(16'(16'h0500 + k), 4'($urandom_range(0, 15)), $urandom, 32'hFFFF_FFFF, 32'd0);
        send_req(REQ_CLEAR, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
        send_req(REQ_GET, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        quiet    = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++)
            put(16'(16'h0600 + k), 4'($urandom_range(0, 15)), $urandom, 32'hFFFF_FFFF, 32'd0);
        quiet = 1'b0;
        send_req(REQ_CLEAR, 16'h0, 4'h0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic random_item();
        int          r;
        logic [15:0] id;
        logic [3:0]  prio;
        logic [31:0] start;
        logic [31:0] tmo;
        r        = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 40);
        id       = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
        prio     = 4'($urandom_range(0, 15));
        start    = clock_ms - $urandom_range(0, 120);
        if ($urandom_range(0, 9) == 0) start = $urandom;
        tmo      = $urandom_range(0, 400);
        if ($urandom_range(0, 9) == 0) tmo = $urandom;
        if (r < 42)      put(id, prio, start, tmo, clock_ms);
        else if (r < 64) send_req(REQ_GET, id, prio, start, tmo, clock_ms);
        else if (r < 76) send_req(REQ_REMOVE, id, prio, start, tmo, clock_ms);
        else if (r < 88) send_req(REQ_HAS, id, prio, start, tmo, clock_ms);
        else if (r < 95) send_req(REQ_CLEAR, id, prio, start, tmo, clock_ms);
        else send_req(3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI)), id, prio, start, tmo,
                      clock_ms);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            cfg_write(CFG_MAX_ENTRIES, 5'($urandom_range(1, 16)));
            cfg_write(CFG_CLEAR_THR, 5'($urandom_range(0, 15)));
            cfg_write(CFG_DEFAULT_PRI, 5'($urandom_range(0, 15)));
            quiet = (phase == 2);
            clock_ms = (phase == 3) ? 32'hFFFF_FE00 : $urandom;
            for (int k = 0; k < 130; k++) random_item();
        end
        quiet = 1'b0;
    endtask

    initial begin
        errors          = 0;
        sent_items      = 0;
        got_results     = 0;
        idle_cycles     = 0;
        overloads       = 0;
        expirations     = 0;
        pend_wr         = 0;
        pend_rd         = 0;
        hold_req        = 1'b0;
        quiet           = 1'b0;
        clock_ms        = '0;
        model_len       = 0;
        lim_entries     = 5'd16;
        lim_clear_thr   = 4'd2;
        lim_default_pri = 4'd3;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_req_type     = '0;
        i_entry_id     = '0;
        i_priority_req = '0;
        i_start_time   = '0;
        i_timeout_ms   = '0;
        i_now          = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_defaults();
        test_ordering_and_ops();
        test_limits();
        test_backpressure();
        test_random();

        wait_idle();
        $display("%0d requests and %0d results checked; %0d overloads, %0d expiries modeled",
                 sent_items, got_results, overloads, expirations);
        $display("coverage: all request kinds, size limits 1..16, ordering ties, long hold-off");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
